// ===== design/rtwk_pkg.sv =====
// rtwk_pkg: shared types and constants for the twinkle led effect unit
// no dependencies; imported by every module of the block but rtwk_ram

package rtwk_pkg;

    // sizes of the effect
    localparam int LED_COUNT = 128;
    localparam int HUE_RANGE = 360;
    localparam int SAT_MAX   = 100;
    localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

    // draw handling
    localparam int TOGGLE_SPAN  = 100;
    localparam int TOGGLE_BELOW = 4;
    localparam int GOAL_FLOOR   = 40;
    localparam int JITTER_MID   = 30;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_SMOOTH      = 3'd0,
        REG_HUE_JIT     = 3'd1,
        REG_SAT_JIT     = 3'd2,
        REG_BASE_HUE    = 3'd3,
        REG_BASE_SAT    = 3'd4,
        REG_BASE_BRIGHT = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic       smooth;
        logic       hue_jit_en;
        logic       sat_jit_en;
        logic [8:0] base_hue;
        logic [6:0] base_sat;
        logic [7:0] base_bright;
    } cfg_t;

    // per-led stored state
    typedef struct packed {
        logic [7:0]        level_now;
        logic [7:0]        level_goal;
        logic signed [6:0] hue_jit;
        logic signed [6:0] sat_jit;
    } led_state_t;

    // what the color stage needs of one led
    typedef struct packed {
        logic [7:0]        level;
        logic signed [6:0] hue_jit;
        logic signed [6:0] sat_jit;
    } pix_t;

endpackage

// ===== design/rtwk_ram.sv =====
// rtwk_ram: generic single write port ram with registered read
// no dependencies

module rtwk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rtwk_update.sv =====
// rtwk_update: per-led target toggle, jitter redraw and level ramp
// depends on rtwk_pkg

module rtwk_update (
    input  rtwk_pkg::led_state_t state_cur,
    input  rtwk_pkg::cfg_t       cfg,
    input  logic [6:0]           toggle_draw,
    input  logic [5:0]           level_draw,
    input  logic [5:0]           hue_draw,
    input  logic [5:0]           sat_draw,
    input  logic [7:0]           step_rate,
    output rtwk_pkg::led_state_t state_next
);
    import rtwk_pkg::*;

    logic       toggle_hit;
    logic [8:0] rate9;
    logic [8:0] cur9;
    logic [8:0] tgt9;
    logic [8:0] up_sum;
    logic [8:0] down_lim;
    led_state_t st;

    // toggle_draw % 100 < 4, with draws up to 127 wrapping once
    assign toggle_hit = (toggle_draw < 7'(TOGGLE_BELOW))
                     || ((toggle_draw >= 7'(TOGGLE_SPAN))
                         && (toggle_draw < 7'(TOGGLE_SPAN + TOGGLE_BELOW)));

    // zero step behaves as one
    assign rate9 = (step_rate == 8'd0) ? 9'd1 : {1'b0, step_rate};

    always_comb
    begin
        st = state_cur;
        if (toggle_hit)
        begin
            if (state_cur.level_goal == 8'd0)
            begin
                st.level_goal = 8'(GOAL_FLOOR) + {2'b00, level_draw};
                if (cfg.hue_jit_en)
                begin
                    st.hue_jit = {1'b0, hue_draw} - 7'(JITTER_MID);
                end
                if (cfg.sat_jit_en)
                begin
                    st.sat_jit = {1'b0, sat_draw} - 7'(JITTER_MID);
                end
            end
            else
            begin
                st.level_goal = 8'd0;
            end
        end
    end

    assign cur9     = {1'b0, state_cur.level_now};
    assign tgt9     = {1'b0, st.level_goal};
    assign up_sum   = cur9 + rate9;
    assign down_lim = tgt9 + rate9;

    always_comb
    begin
        state_next = st;
        if (cfg.smooth)
        begin
            if (cur9 < tgt9)
            begin
                state_next.level_now = (up_sum < tgt9) ? up_sum[7:0] : st.level_goal;
            end
            else if (cur9 > tgt9)
            begin
                // cur - rate > goal, written without going negative
                state_next.level_now = (cur9 > down_lim)
                                     ? 8'(cur9 - rate9) : st.level_goal;
            end
            else
            begin
                state_next.level_now = state_cur.level_now;
            end
        end
        else
        begin
            state_next.level_now = st.level_goal;
        end
    end

endmodule

// ===== design/rtwk_color.sv =====
// rtwk_color: hue wrap, saturation clamp and brightness scale of one led
// depends on rtwk_pkg

module rtwk_color (
    input  rtwk_pkg::pix_t pix,
    input  rtwk_pkg::cfg_t cfg,
    output logic           lit,
    output logic [8:0]     hue,
    output logic [6:0]     sat,
    output logic [7:0]     bright
);
    import rtwk_pkg::*;

    logic signed [6:0]  hj_app;
    logic signed [6:0]  sj_app;
    logic signed [10:0] h_sum;
    logic signed [10:0] h_wrap;
    logic signed [8:0]  s_sum;
    logic [6:0]         s_clamp;
    logic [15:0]        prod;
    logic [16:0]        quot_sum;

    assign hj_app = cfg.hue_jit_en ? pix.hue_jit : 7'sd0;
    assign sj_app = cfg.sat_jit_en ? pix.sat_jit : 7'sd0;

    assign h_sum = $signed({2'b00, cfg.base_hue}) + $signed({{4{hj_app[6]}}, hj_app});
    assign s_sum = $signed({2'b00, cfg.base_sat}) + $signed({{2{sj_app[6]}}, sj_app});

    // sum stays within one range of either side
    always_comb
    begin
        if (h_sum < 11'sd0)
        begin
            h_wrap = h_sum + 11'(HUE_RANGE);
        end
        else if (h_sum >= $signed(11'(HUE_RANGE)))
        begin
            h_wrap = h_sum - 11'(HUE_RANGE);
        end
        else
        begin
            h_wrap = h_sum;
        end
    end

    always_comb
    begin
        if (s_sum < 9'sd0)
        begin
            s_clamp = 7'd0;
        end
        else if (s_sum > $signed(9'(SAT_MAX)))
        begin
            s_clamp = 7'(SAT_MAX);
        end
        else
        begin
            s_clamp = s_sum[6:0];
        end
    end

    // x / 255 as (x + (x >> 8) + 1) >> 8, exact for any 8 by 8 product
    assign prod     = 16'(cfg.base_bright) * 16'(pix.level);
    assign quot_sum = 17'(prod) + 17'(prod[15:8]) + 17'd1;

    assign lit    = (pix.level != 8'd0);
    assign hue    = lit ? h_wrap[8:0] : 9'd0;
    assign sat    = lit ? s_clamp : 7'd0;
    assign bright = lit ? quot_sum[15:8] : 8'd0;

endmodule

// ===== design/random_twinkle_led_effect_unit.sv =====
// random_twinkle_led_effect_unit: top level of the twinkle led effect
// depends on rtwk_pkg, rtwk_ram, rtwk_update, rtwk_color
//
// usage
// - input channel (in_valid/in_ready) carries one beat per led per frame:
//   the led index, the random draws already reduced to range, the ramp
//   step of this frame and a last-led mark
// - output channel (out_valid/out_ready) returns one beat per input beat,
//   in order: index, lit flag, hue, saturation, brightness, frame end
// - configuration is a plain write port (cfg_we, cfg_index, cfg_data); the user
//   writes registers only while the unit is idle, the unit does not enforce it
// - throughput: one beat per cycle while the receiver does not stall, set by
//   the read-modify-write of the per-led state ram (a bypass covers
//   back-to-back beats to the same led)
// - path of a beat: ram read into the input register, then state update into
//   stage 2, then color and brightness into the output register
// - reset clears the control state and the per-led valid bits, so every
//   led starts dark with zero jitter; base_bright comes up as 100
// - when the receiver stalls, the three stages fill and in_ready drops
//   only once all of them hold a beat; no beat is lost or repeated

module random_twinkle_led_effect_unit (
    input  logic       clk,
    input  logic       rst_n,
    // configuration
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [8:0] cfg_data,
    // input beats
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [6:0] led_index,
    input  logic [6:0] toggle_draw,
    input  logic [5:0] level_draw,
    input  logic [5:0] hue_draw,
    input  logic [5:0] sat_draw,
    input  logic [7:0] step_rate,
    input  logic       last_led,
    // result beats
    output logic       out_valid,
    input  logic       out_ready,
    output logic [6:0] out_index,
    output logic       lit,
    output logic [8:0] out_hue,
    output logic [6:0] out_sat,
    output logic [7:0] out_bright,
    output logic       frame_end
);
    import rtwk_pkg::*;

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smooth      <= 1'b0;
            cfg_reg.hue_jit_en  <= 1'b0;
            cfg_reg.sat_jit_en  <= 1'b0;
            cfg_reg.base_hue    <= 9'd0;
            cfg_reg.base_sat    <= 7'd0;
            cfg_reg.base_bright <= 8'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SMOOTH:      cfg_reg.smooth      <= cfg_data[0];
                REG_HUE_JIT:     cfg_reg.hue_jit_en  <= cfg_data[0];
                REG_SAT_JIT:     cfg_reg.sat_jit_en  <= cfg_data[0];
                REG_BASE_HUE:    cfg_reg.base_hue    <= cfg_data;
                REG_BASE_SAT:    cfg_reg.base_sat    <= cfg_data[6:0];
                REG_BASE_BRIGHT: cfg_reg.base_bright <= cfg_data[7:0];
                default:         ; // unused indexes are dropped
            endcase
        end
    end

    // pipeline flow control
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s2_free;
    logic s1_free;
    logic s2_adv;
    logic s1_adv;
    logic in_acc;

    assign out_free = !out_valid_reg || out_ready;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign in_acc   = in_valid && s1_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // stage 1: input register, ram read in flight
    logic [6:0]  s1_idx_reg;
    logic [6:0]  s1_toggle_reg;
    logic [5:0]  s1_ldraw_reg;
    logic [5:0]  s1_hdraw_reg;
    logic [5:0]  s1_sdraw_reg;
    logic [7:0]  s1_rate_reg;
    logic        s1_last_reg;
    logic        s1_in_range_reg;

    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              wr_en;
    logic              in_range;

    assign in_range = (int'(led_index) < LED_COUNT);
    assign rd_addr  = ADDR_W'(led_index);
    assign wr_addr  = ADDR_W'(s1_idx_reg);
    assign wr_en    = s1_adv && s1_in_range_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_idx_reg      <= led_index;
            s1_toggle_reg   <= toggle_draw;
            s1_ldraw_reg    <= level_draw;
            s1_hdraw_reg    <= hue_draw;
            s1_sdraw_reg    <= sat_draw;
            s1_rate_reg     <= step_rate;
            s1_last_reg     <= last_led;
            s1_in_range_reg <= in_range;
        end
    end

    // per-led state ram, valid bits stand in for the cleared contents
    led_state_t        ram_rdata;
    led_state_t        state_cur;
    led_state_t        state_next;
    led_state_t        fwd_data_reg;
    logic              fwd_hit_reg;
    logic              vld_rd_reg;
    logic [LED_COUNT-1:0] valid_reg;

    rtwk_ram #(
        .WIDTH ($bits(led_state_t)),
        .DEPTH (LED_COUNT)
    ) u_state_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (state_next),
        .re    (in_acc),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            fwd_hit_reg <= 1'b0;
            vld_rd_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (in_acc)
            begin
                // same led written at the edge it is read: take the new entry
                fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
                vld_rd_reg  <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            fwd_data_reg <= state_next;
        end
    end

    always_comb
    begin
        if (fwd_hit_reg)
        begin
            state_cur = fwd_data_reg;
        end
        else if (vld_rd_reg)
        begin
            state_cur = ram_rdata;
        end
        else
        begin
            state_cur = '0;
        end
    end

    rtwk_update u_update (
        .state_cur   (state_cur),
        .cfg         (cfg_reg),
        .toggle_draw (s1_toggle_reg),
        .level_draw  (s1_ldraw_reg),
        .hue_draw    (s1_hdraw_reg),
        .sat_draw    (s1_sdraw_reg),
        .step_rate   (s1_rate_reg),
        .state_next  (state_next)
    );

    // stage 2: updated level and jitter of the led
    pix_t       s2_pix_reg;
    pix_t       pix_next;
    logic [6:0] s2_idx_reg;
    logic       s2_last_reg;

    always_comb
    begin
        pix_next.level   = s1_in_range_reg ? state_next.level_now : 8'd0;
        pix_next.hue_jit = state_next.hue_jit;
        pix_next.sat_jit = state_next.sat_jit;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_pix_reg  <= pix_next;
            s2_idx_reg  <= s1_idx_reg;
            s2_last_reg <= s1_last_reg;
        end
    end

    // color stage into the output register
    logic       lit_next;
    logic [8:0] hue_next;
    logic [6:0] sat_next;
    logic [7:0] bright_next;

    rtwk_color u_color (
        .pix    (s2_pix_reg),
        .cfg    (cfg_reg),
        .lit    (lit_next),
        .hue    (hue_next),
        .sat    (sat_next),
        .bright (bright_next)
    );

    logic [6:0] out_index_reg;
    logic       lit_reg;
    logic [8:0] out_hue_reg;
    logic [6:0] out_sat_reg;
    logic [7:0] out_bright_reg;
    logic       frame_end_reg;

    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_index_reg  <= s2_idx_reg;
            lit_reg        <= lit_next;
            out_hue_reg    <= hue_next;
            out_sat_reg    <= sat_next;
            out_bright_reg <= bright_next;
            frame_end_reg  <= s2_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_index  = out_index_reg;
    assign lit        = lit_reg;
    assign out_hue    = out_hue_reg;
    assign out_sat    = out_sat_reg;
    assign out_bright = out_bright_reg;
    assign frame_end  = frame_end_reg;

`ifndef SYNTHESIS
    // without smooth ramp the level lands on the goal at once
    a_jump_to_goal: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !cfg_reg.smooth |-> state_next.level_now == state_next.level_goal)
        else $error("level does not match goal in jump mode");

    // a goal is either off or at least the floor level
    a_goal_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_next.level_goal == 8'd0)
               || (state_next.level_goal >= 8'(GOAL_FLOOR)))
        else $error("goal level below floor");

    // a dark pixel carries no color
    a_dark_black: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !lit_reg |-> (out_bright_reg == 8'd0)
                                   && (out_hue_reg == 9'd0) && (out_sat_reg == 7'd0))
        else $error("unlit pixel has nonzero color");

    // stage 2 holds its beat while the output is blocked
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !out_free |=> s2_valid_reg && $stable(s2_idx_reg))
        else $error("stage 2 beat lost under stall");

    // a same-led beat right behind a write picks up the bypass
    a_fwd_owner: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && wr_en && (wr_addr == rd_addr) |=> fwd_hit_reg)
        else $error("bypass missed for back-to-back beats to one led");
`endif

endmodule
